FILE: sv/etc1_pkg.sv
// shared types, constants and functions for the etc1 block decoder
`default_nettype none

package etc1_pkg;

    localparam int unsigned PIXELS      = 16;
    localparam int unsigned PIX_IDX_W   = $clog2(PIXELS);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    // register index taken from paddr[2]
    localparam logic REG_MERGE_ALPHA = 1'b0;

    typedef logic [7:0] t_chan;

    typedef struct packed {
        t_chan [2:0] base0;
        t_chan [2:0] base1;
        logic  [2:0] cw0;
        logic  [2:0] cw1;
        logic        flip;
        logic [31:0] sel;
    } t_job;

    // 5-bit to 8-bit widening of an 8-bit value, truncated to 8 bits
    function automatic t_chan widen5(input logic [7:0] c);
        t_chan w;
        w = {c[4:0], 3'b000} | {2'b00, c[7:2]};
        return w;
    endfunction

    // modifier table row, remapped selector column
    function automatic logic signed [8:0] mod_value(input logic [2:0] cw,
                                                    input logic [1:0] code);
        logic [7:0]        mag_far;
        logic [7:0]        mag_near;
        logic [7:0]        mag;
        logic signed [8:0] v;
        case (cw)
            3'd0:    begin mag_far = 8'd8;   mag_near = 8'd2;  end
            3'd1:    begin mag_far = 8'd17;  mag_near = 8'd5;  end
            3'd2:    begin mag_far = 8'd29;  mag_near = 8'd9;  end
            3'd3:    begin mag_far = 8'd42;  mag_near = 8'd13; end
            3'd4:    begin mag_far = 8'd60;  mag_near = 8'd18; end
            3'd5:    begin mag_far = 8'd80;  mag_near = 8'd24; end
            3'd6:    begin mag_far = 8'd106; mag_near = 8'd33; end
            default: begin mag_far = 8'd183; mag_near = 8'd47; end
        endcase
        // code {msb,lsb}: 0 -> +near, 1 -> +far, 2 -> -near, 3 -> -far
        mag = code[0] ? mag_far : mag_near;
        v   = code[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        return v;
    endfunction

    function automatic t_chan clamp_add(input t_chan base, input logic signed [8:0] m);
        logic signed [9:0] s;
        t_chan             r;
        s = $signed({2'b00, base}) + $signed({m[8], m});
        if (s < 0) begin
            r = 8'd0;
        end else if (s > 10'sd255) begin
            r = 8'd255;
        end else begin
            r = s[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/etc1_front.sv
// front end: accepts a block and decodes bases and codewords
`default_nettype none

module etc1_front (
    input  wire logic            i_in_valid,
    input  wire logic [31:0]     i_endpoint_word,
    input  wire logic [31:0]     i_selector_word,
    output logic                 o_push,
    output etc1_pkg::t_job       o_job
);
    import etc1_pkg::*;

    logic       diff;
    logic [4:0] c;
    logic [2:0] d;
    logic [7:0] dx;
    logic [7:0] c2;
    logic [3:0] a;
    logic [3:0] b;

    assign diff   = i_endpoint_word[1];
    assign o_push = i_in_valid;

    always_comb begin
        o_job      = '0;
        o_job.cw0  = i_endpoint_word[7:5];
        o_job.cw1  = i_endpoint_word[4:2];
        o_job.flip = i_endpoint_word[0];
        o_job.sel  = i_selector_word;
        c  = '0;
        d  = '0;
        dx = '0;
        c2 = '0;
        a  = '0;
        b  = '0;
        for (int ch = 0; ch < 3; ch++) begin
            a  = i_endpoint_word[28 - 8*ch +: 4];
            b  = i_endpoint_word[24 - 8*ch +: 4];
            c  = i_endpoint_word[27 - 8*ch +: 5];
            d  = i_endpoint_word[24 - 8*ch +: 3];
            dx = {{5{d[2]}}, d};
            c2 = {3'b000, c} + dx;
            if (diff) begin
                o_job.base0[ch] = widen5({3'b000, c});
                o_job.base1[ch] = widen5(c2);
            end else begin
                o_job.base0[ch] = {a, a};
                o_job.base1[ch] = {b, b};
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/etc1_queue.sv
// short queue of decoded blocks between front and back
`default_nettype none

module etc1_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire etc1_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_job_valid,
    output etc1_pkg::t_job       o_job
);
    import etc1_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_pop && o_job_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: sv/etc1_back.sv
// back end: walks the 16 pixels of a decoded block into the output register
`default_nettype none

module etc1_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_merge_alpha,
    input  wire logic            i_job_valid,
    input  wire etc1_pkg::t_job  i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_alpha,
    output logic [1:0]           o_pixel_col,
    output logic [1:0]           o_pixel_row,
    output logic                 o_last_pixel
);
    import etc1_pkg::*;

    t_job                 r_job;
    logic                 r_busy;
    logic [PIX_IDX_W-1:0] r_idx;
    logic                 r_out_valid;
    logic [7:0]           r_red;
    logic [7:0]           r_green;
    logic [7:0]           r_blue;
    logic [7:0]           r_alpha;
    logic [1:0]           r_col;
    logic [1:0]           r_row;
    logic                 r_last;

    logic                 n_busy;
    logic [PIX_IDX_W-1:0] n_idx;
    logic                 n_out_valid;

    logic                 advance;
    logic                 is_last;
    logic                 take;
    logic                 half;
    logic                 msb;
    logic                 lsb;
    logic [2:0]           cw;
    t_chan [2:0]          base;
    logic signed [8:0]    m;
    t_chan                pr;
    t_chan                pg;
    t_chan                pb;

    assign advance = r_busy && (!r_out_valid || !i_out_stall);
    assign is_last = (r_idx == PIX_IDX_W'(PIXELS - 1));
    assign take    = i_job_valid && (!r_busy || (advance && is_last));
    assign o_pop   = take;

    always_comb begin
        half = r_job.flip ? r_idx[1] : r_idx[3];
        msb  = r_job.sel[{1'b1, r_idx}];
        lsb  = r_job.sel[{1'b0, r_idx}];
        cw   = half ? r_job.cw1 : r_job.cw0;
        base = half ? r_job.base1 : r_job.base0;
        m    = mod_value(cw, {msb, lsb});
        pr   = clamp_add(base[0], m);
        pg   = clamp_add(base[1], m);
        pb   = clamp_add(base[2], m);
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (take) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (advance) begin
            n_busy = !is_last;
            n_idx  = r_idx + 1'b1;
        end
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        if (advance) begin
            if (i_merge_alpha) begin
                r_red   <= 8'd0;
                r_green <= 8'd0;
                r_blue  <= 8'd0;
                r_alpha <= pg;
            end else begin
                r_red   <= pr;
                r_green <= pg;
                r_blue  <= pb;
                r_alpha <= 8'd255;
            end
            r_col  <= r_idx[3:2];
            r_row  <= r_idx[1:0];
            r_last <= is_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_alpha      = r_alpha;
    assign o_pixel_col  = r_col;
    assign o_pixel_row  = r_row;
    assign o_last_pixel = r_last;

endmodule

`default_nettype wire

FILE: sv/etc1_block_decoder.sv
// top level of the etc1 block decoder with its register port
// usage:
//   input channel (i_in_valid / o_in_stall) takes one 64-bit etc1 block per
//   transfer as i_endpoint_word (block bits 63..32) and i_selector_word
//   (bits 31..0).
//   output channel (o_out_valid / i_out_stall) gives 16 pixel transfers per
//   block in order col*4+row, o_last_pixel marking the sixteenth.
//   when the queue and back end are empty, the first pixel of a block shows
//   after its queue entry, the back end job register and the output register.
//   one pixel leaves per cycle while the receiver does not stall; blocks
//   follow each other with no gap, set by the back end pixel counter.
//   a two-entry queue of decoded blocks sits between front and back, so
//   input is taken while pixels of earlier blocks still drain.
//   when the receiver stalls the output register holds its pixel; the
//   queue then fills and o_in_stall rises.
//   reset (synchronous, active low) empties the queue, drops any block in
//   flight and clears merge_alpha (register 0, byte address 0) to 0.
`default_nettype none

module etc1_block_decoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [etc1_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [etc1_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [etc1_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [31:0]                     i_endpoint_word,
    input  wire logic [31:0]                     i_selector_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_red,
    output logic [7:0]                           o_green,
    output logic [7:0]                           o_blue,
    output logic [7:0]                           o_alpha,
    output logic [1:0]                           o_pixel_col,
    output logic [1:0]                           o_pixel_row,
    output logic                                 o_last_pixel
);
    import etc1_pkg::*;

    logic r_merge_alpha;
    logic n_merge_alpha;
    logic reg_write;
    logic reg_hit;
    logic push;
    logic full;
    logic pop;
    logic job_valid;
    t_job front_job;
    t_job queue_job;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == REG_MERGE_ALPHA);
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? {{(APB_DATA_W - 1){1'b0}}, r_merge_alpha} : '0;

    always_comb begin
        n_merge_alpha = r_merge_alpha;
        if (reg_write && reg_hit) begin
            n_merge_alpha = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_alpha <= 1'b0;
        end else begin
            r_merge_alpha <= n_merge_alpha;
        end
    end

    assign o_in_stall = full;

    etc1_front u_front (
        .i_in_valid      (i_in_valid),
        .i_endpoint_word (i_endpoint_word),
        .i_selector_word (i_selector_word),
        .o_push          (push),
        .o_job           (front_job)
    );

    etc1_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (front_job),
        .o_full      (full),
        .i_pop       (pop),
        .o_job_valid (job_valid),
        .o_job       (queue_job)
    );

    etc1_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_merge_alpha (r_merge_alpha),
        .i_job_valid   (job_valid),
        .i_job         (queue_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_pixel_col   (o_pixel_col),
        .o_pixel_row   (o_pixel_row),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

`default_nettype wire
